### hw/rtl/random_pick_without_replacement_defines.svh
// ----------------------------------------------------------------------------
// random pick without replacement - assertion macros
// shared concurrent assertion helpers, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef RANDOM_PICK_WITHOUT_REPLACEMENT_DEFINES_SVH
`define RANDOM_PICK_WITHOUT_REPLACEMENT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define RPWR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RPWR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RPWR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define RPWR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### hw/rtl/rpwr_pkg.sv
// ----------------------------------------------------------------------------
// rpwr_pkg
// types and constants shared by the random pick blocks
// ----------------------------------------------------------------------------
package rpwr_pkg;

    localparam int KIND_W  = 2;
    localparam int RND_W   = 32;
    localparam int ENTRY_W = 7;
    localparam int COUNT_W = 7;
    localparam int STEP_W  = $clog2(RND_W);

    // transaction kinds; the unused code behaves as a status request
    typedef enum logic [KIND_W-1:0] {
        KIND_RESTART = 2'd0,
        KIND_ADVANCE = 2'd1,
        KIND_STATUS  = 2'd2
    } t_kind;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // latch input transaction
        logic prep;       // apply restart / mark done, set up divider
        logic div_step;   // one restoring division step
        logic rcp_mul;    // random word times reciprocal of the entry count
        logic rcp_quo;    // quotient of the random word by the entry count
        logic take_rem;   // current entry from remainder
        logic scan_step;  // visit one bitmap entry
        logic out_load;   // fill output register
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic is_restart;
        logic is_advance;
        logic div_last;
        logic scan_hit;
        logic out_free;
    } t_dp_sts;

endpackage

### hw/rtl/rpwr_if.sv
// ----------------------------------------------------------------------------
// rpwr_if
// valid/ready channels for request and result transactions
// ----------------------------------------------------------------------------
interface rpwr_in_if
    import rpwr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [RND_W-1:0]    random_value;

    modport source (output valid, output kind, output random_value, input ready);
    modport sink   (input valid, input kind, input random_value, output ready);
endinterface

interface rpwr_out_if
    import rpwr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ENTRY_W-1:0]  current_entry;
    logic [COUNT_W-1:0]  remaining_count;
    logic                wrapped;

    modport source (output valid, output current_entry, output remaining_count,
                    output wrapped, input ready);
    modport sink   (input valid, input current_entry, input remaining_count,
                    input wrapped, output ready);
endinterface

### hw/rtl/rpwr_ctrl.sv
// ----------------------------------------------------------------------------
// rpwr_ctrl
// sequencing state machine for the random pick datapath
// ----------------------------------------------------------------------------
module rpwr_ctrl
    import rpwr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_PREP = 8'b00000010,
        S_DIV  = 8'b00000100,
        S_MUL  = 8'b00001000,
        S_QUO  = 8'b00010000,
        S_SET  = 8'b00100000,
        S_SCAN = 8'b01000000,
        S_FIN  = 8'b10000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                if (i_sts.is_advance) begin
                    n_state = S_DIV;
                end else if (i_sts.is_restart) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_SCAN;
                end
            end
            S_MUL: begin
                o_cmd.rcp_mul = 1'b1;
                n_state       = S_QUO;
            end
            S_QUO: begin
                o_cmd.rcp_quo = 1'b1;
                n_state       = S_SET;
            end
            S_SET: begin
                o_cmd.take_rem = 1'b1;
                n_state        = S_FIN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_hit) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/rpwr_dp.sv
// ----------------------------------------------------------------------------
// rpwr_dp
// done bitmap, open count, reciprocal and serial modulo, bitmap scan and
// output register
// ----------------------------------------------------------------------------
`include "random_pick_without_replacement_defines.svh"

module rpwr_dp
    import rpwr_pkg::*;
#(
    parameter int ENTRIES = 100
)(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [KIND_W-1:0]        i_kind,
    input  logic [RND_W-1:0]         i_random_value,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    rpwr_out_if.source               o_out
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int REM_W = $clog2(ENTRIES + 1);
    localparam logic [REM_W-1:0] N_ENT = REM_W'(ENTRIES);
    // floor(2^(32 + IDX_W) / ENTRIES) + 1 gives an exact quotient for any 32-bit word
    localparam logic [RND_W:0] RCP =
        (RND_W + 1)'(((64'd1 << (RND_W + IDX_W)) / 64'(ENTRIES)) + 64'd1);
    localparam logic [IDX_W-1:0] ENT_LOW = IDX_W'(ENTRIES);

    logic [ENTRIES-1:0]  r_done, n_done;
    logic [IDX_W-1:0]    r_cur, n_cur;
    logic [REM_W-1:0]    r_cnt, n_cnt;
    logic                r_wrap, n_wrap;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [RND_W-1:0]    r_dvd, n_dvd;
    logic [REM_W-1:0]    r_dvs, n_dvs;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [RND_W-1:0]    r_prod, n_prod;
    logic [IDX_W-1:0]    r_quo, n_quo;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [REM_W-1:0]    r_seen, n_seen;
    logic                r_out_valid, n_out_valid;
    logic [ENTRY_W-1:0]  r_out_entry, n_out_entry;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;
    logic                r_out_wrap, n_out_wrap;

    logic [REM_W-1:0]    cnt_after;
    logic [REM_W:0]      trial;
    logic                out_free;
    logic [2*RND_W-1:0]  rcp_prod;
    logic [RND_W:0]      rcp_sum;
    logic [IDX_W-1:0]    quo_prod;

    assign cnt_after = r_done[r_cur] ? r_cnt : (r_cnt - REM_W'(1));
    assign trial     = {r_rem, r_dvd[RND_W-1]};
    assign out_free  = !r_out_valid || o_out.ready;

    // quotient = (x * RCP) >> (32 + IDX_W), with the top reciprocal bit added as x
    assign rcp_prod = {{RND_W{1'b0}}, r_dvd} * {{RND_W{1'b0}}, RCP[RND_W-1:0]};
    assign rcp_sum  = {1'b0, r_prod} + (RCP[RND_W] ? {1'b0, r_dvd} : '0);
    // remainder only needs the low bits of quotient times entry count
    assign quo_prod = r_quo * ENT_LOW;

    assign o_sts.is_restart = (r_kind == KIND_RESTART);
    assign o_sts.is_advance = (r_kind == KIND_ADVANCE);
    assign o_sts.div_last   = (r_step == STEP_W'(RND_W - 1));
    assign o_sts.scan_hit   = !r_done[r_idx] && (r_seen == r_rem);
    assign o_sts.out_free   = out_free;

    always_comb begin
        n_done      = r_done;
        n_cur       = r_cur;
        n_cnt       = r_cnt;
        n_wrap      = r_wrap;
        n_kind      = r_kind;
        n_dvd       = r_dvd;
        n_dvs       = r_dvs;
        n_rem       = r_rem;
        n_step      = r_step;
        n_prod      = r_prod;
        n_quo       = r_quo;
        n_idx       = r_idx;
        n_seen      = r_seen;
        n_out_valid = r_out_valid;
        n_out_entry = r_out_entry;
        n_out_count = r_out_count;
        n_out_wrap  = r_out_wrap;

        if (i_cmd.load) begin
            n_kind = i_kind;
            n_dvd  = i_random_value;
        end

        if (i_cmd.prep) begin
            n_rem  = '0;
            n_step = '0;
            n_idx  = '0;
            n_seen = '0;
            n_wrap = 1'b0;
            priority if (r_kind == KIND_RESTART) begin
                n_done = '0;
                n_cnt  = N_ENT;
                n_dvs  = N_ENT;
            end else if (r_kind == KIND_ADVANCE) begin
                if (cnt_after == '0) begin
                    // every entry used up: start a fresh round
                    n_done = '0;
                    n_cnt  = N_ENT;
                    n_dvs  = N_ENT;
                    n_wrap = 1'b1;
                end else begin
                    n_done[r_cur] = 1'b1;
                    n_cnt         = cnt_after;
                    n_dvs         = cnt_after;
                end
            end else begin
                // status: bitmap and count left alone
            end
        end

        if (i_cmd.div_step) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = REM_W'(trial - {1'b0, r_dvs});
            end else begin
                n_rem = REM_W'(trial);
            end
            n_dvd  = {r_dvd[RND_W-2:0], 1'b0};
            n_step = r_step + STEP_W'(1);
        end

        if (i_cmd.rcp_mul) begin
            n_prod = rcp_prod[2*RND_W-1:RND_W];
        end

        if (i_cmd.rcp_quo) begin
            n_quo = rcp_sum[IDX_W +: IDX_W];
        end

        if (i_cmd.take_rem) begin
            n_cur = r_dvd[IDX_W-1:0] - quo_prod;
        end

        if (i_cmd.scan_step) begin
            if (!r_done[r_idx]) begin
                if (r_seen == r_rem) begin
                    n_cur = r_idx;
                end else begin
                    n_seen = r_seen + REM_W'(1);
                end
            end
            n_idx = r_idx + IDX_W'(1);
        end

        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
            n_out_entry = ENTRY_W'(r_cur);
            n_out_count = COUNT_W'(r_cnt);
            n_out_wrap  = r_wrap;
        end else if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_cur       <= '0;
            r_cnt       <= N_ENT;
            r_out_valid <= 1'b0;
        end else begin
            r_done      <= n_done;
            r_cur       <= n_cur;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wrap      <= n_wrap;
        r_kind      <= n_kind;
        r_dvd       <= n_dvd;
        r_dvs       <= n_dvs;
        r_rem       <= n_rem;
        r_step      <= n_step;
        r_prod      <= n_prod;
        r_quo       <= n_quo;
        r_idx       <= n_idx;
        r_seen      <= n_seen;
        r_out_entry <= n_out_entry;
        r_out_count <= n_out_count;
        r_out_wrap  <= n_out_wrap;
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.current_entry   = r_out_entry;
    assign o_out.remaining_count = r_out_count;
    assign o_out.wrapped         = r_out_wrap;

    `RPWR_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1,
        (r_cnt != '0) && (r_cnt <= N_ENT), "open count out of range")

    `RPWR_ASSERT_IMP(a_cur_open, i_clk, i_rst_n, i_cmd.out_load,
        !r_done[r_cur], "reported entry is already marked done")

    `RPWR_ASSERT_IMP(a_scan_bound, i_clk, i_rst_n, i_cmd.scan_step,
        ({1'b0, r_idx} < (IDX_W + 1)'(ENTRIES)), "bitmap scan ran past last entry")

    `RPWR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_valid && !o_out.ready,
        r_out_valid && $stable(r_out_entry) && $stable(r_out_count),
        "pending result changed before it was taken")

endmodule

### hw/rtl/random_pick_without_replacement.sv
// ----------------------------------------------------------------------------
// random_pick_without_replacement
// picks entries at random without repeats, using a done bitmap
// ----------------------------------------------------------------------------
//
// channel  dir  payload                                      purpose
// i_in     in   kind, random_value                           restart / advance / status
// o_out    out  current_entry, remaining_count, wrapped      one result per transaction
//
// steps per transaction: status goes through prep to the result; restart adds a
//   reciprocal multiply, quotient and remainder for the modulo by ENTRIES; advance adds
//   a 32-step serial modulo by the open count, then scans one bitmap entry a cycle
// the next transaction is taken once the result sits in the output register; a stalled
//   sink holds the controller only while that register is still full
// synchronous active-low reset clears the bitmap and selects entry zero
//
`include "random_pick_without_replacement_defines.svh"

module random_pick_without_replacement
    import rpwr_pkg::*;
#(
    parameter int ENTRIES = 100
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rpwr_in_if.sink     i_in,
    rpwr_out_if.source  o_out
);

    // command and status between controller and datapath
    t_dp_cmd cmd;
    t_dp_sts sts;

    // controller: sequences prep, modulo, scan and result hand-off
    rpwr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: bitmap, open count, modulo units, scan and output register
    rpwr_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_kind         (i_in.kind),
        .i_random_value (i_in.random_value),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out          (o_out)
    );

    // a transaction is only taken in while the controller holds no work
    `RPWR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready,
        !i_in.ready, "input accepted again before prior transaction finished")

    // a result is only produced from a taken transaction's final step
    `RPWR_ASSERT_IMP(a_load_when_busy, i_clk, i_rst_n, cmd.out_load,
        !i_in.ready && sts.out_free, "result loaded while idle or slot full")

    // a restart transaction never reports a wrap
    `RPWR_ASSERT_NEXT(a_restart_no_wrap, i_clk, i_rst_n, cmd.out_load && sts.is_restart,
        !o_out.wrapped, "restart reported a wrap")

endmodule

### dv/tb_random_pick_without_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_random_pick_without_replacement
// self-checking bench: a local predictor of the done bitmap and current entry
// tracks every accepted request; each result is checked field by field in order
// ----------------------------------------------------------------------------
module tb_random_pick_without_replacement
    import rpwr_pkg::*;
();

    localparam int N_ENTRIES = 100;
    // spare kind code, behaves as a status request
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    // generous watchdog ceiling on the length of the whole run
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [ENTRY_W-1:0] entry;
        logic [COUNT_W-1:0] open_left;
        logic               wrapped;
    } t_pick_result;

    logic i_clk;
    logic i_rst_n;

    rpwr_in_if  in_ch();
    rpwr_out_if out_ch();

    random_pick_without_replacement #(
        .ENTRIES (N_ENTRIES)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predictor state: one done bit per entry plus the current pick
    logic [N_ENTRIES-1:0] done_map;
    logic [ENTRY_W-1:0]   cur_pick;

    // results still owed by the block, oldest first
    t_pick_result pending_picks[$];

    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic int unsigned count_open();
        int unsigned n;
        n = 0;
        for (int i = 0; i < N_ENTRIES; i++) begin
            if (!done_map[i]) n++;
        end
        return n;
    endfunction

    // applies one request to the local state and returns the result it owes
    function automatic t_pick_result next_pick(input logic [KIND_W-1:0] kind,
                                               input logic [RND_W-1:0] rnd);
        t_pick_result r;
        int unsigned  open_left;
        int unsigned  k;
        int unsigned  seen;
        r.wrapped = 1'b0;
        if (kind == KIND_RESTART) begin
            // bitmap cleared, but a restart never reports a wrap
            done_map = '0;
            cur_pick = ENTRY_W'(rnd % N_ENTRIES);
        end else if (kind == KIND_ADVANCE) begin
            done_map[cur_pick] = 1'b1;
            open_left = count_open();
            // every entry used up: start a fresh round
            if (open_left == 0) begin
                done_map  = '0;
                r.wrapped = 1'b1;
                open_left = N_ENTRIES;
            end
            // k-th open entry in ascending index order
            k    = rnd % open_left;
            seen = 0;
            for (int i = 0; i < N_ENTRIES; i++) begin
                if (!done_map[i]) begin
                    if (seen == k) begin
                        cur_pick = ENTRY_W'(i);
                        break;
                    end
                    seen++;
                end
            end
        end
        // status and the spare code leave everything alone
        r.entry     = cur_pick;
        r.open_left = COUNT_W'(count_open());
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // error bookkeeping: first few reported in full, the rest only counted
    // ------------------------------------------------------------------------
    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("%0t ERROR: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // request side: one transaction per call, starts and ends at a falling edge
    // valid stays high between back-to-back calls, so no drop-and-raise
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [RND_W-1:0] rnd);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= kind;
        in_ch.random_value <= rnd;
        do @(posedge i_clk); while (!in_ch.ready);
        // accepted at this edge: predict in acceptance order
        pending_picks.push_back(next_pick(kind, rnd));
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // result side: random back-pressure, checked at the rising edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_pick_result want;
        t_pick_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.entry     = out_ch.current_entry;
            got.open_left = out_ch.remaining_count;
            got.wrapped   = out_ch.wrapped;
            if (pending_picks.size() == 0) begin
                flag_error($sformatf("unexpected result entry=%0d left=%0d wrapped=%0b",
                                     got.entry, got.open_left, got.wrapped));
            end else begin
                want = pending_picks.pop_front();
                if (got.entry !== want.entry || got.open_left !== want.open_left ||
                    got.wrapped !== want.wrapped) begin
                    flag_error($sformatf({"result mismatch: entry exp %0d got %0d, ",
                                          "left exp %0d got %0d, wrapped exp %0b got %0b"},
                                         want.entry, got.entry, want.open_left,
                                         got.open_left, want.wrapped, got.wrapped));
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // after reset: entry zero, every entry open; spare code behaves as status
    task automatic test_reset_state();
        send_item(KIND_STATUS, '0);
        send_item(KIND_SPARE, '1);
        send_item(KIND_STATUS, '1);
    endtask

    // restart with the corners of the random word
    task automatic test_restart_extremes();
        send_item(KIND_RESTART, '0);
        send_item(KIND_RESTART, '1);
        send_item(KIND_RESTART, 32'd99);
        send_item(KIND_RESTART, 32'd100);
        send_item(KIND_RESTART, 32'h8000_0000);
        send_item(KIND_RESTART, 32'h7FFF_FFFF);
        send_item(KIND_STATUS, 32'h5A5A_A5A5);
    endtask

    // advance picks: lowest open and points between
    task automatic test_advance_extremes();
        send_item(KIND_RESTART, '0);
        send_item(KIND_ADVANCE, '0);
        send_item(KIND_ADVANCE, '1);
        send_item(KIND_ADVANCE, 32'h8000_0000);
        send_item(KIND_ADVANCE, 32'd98);
        send_item(KIND_ADVANCE, 32'd1);
        send_item(KIND_STATUS, '0);
        send_item(KIND_RESTART, 32'd99);
        send_item(KIND_ADVANCE, 32'h7FFF_FFFF);
        send_item(KIND_ADVANCE, 32'hFFFF_FFFE);
    endtask

    // spare code in the middle of a round must not disturb the bitmap
    task automatic test_spare_kind();
        send_item(KIND_SPARE, '0);
        send_item(KIND_ADVANCE, 32'h0000_0003);
        send_item(KIND_SPARE, 32'hDEAD_BEEF);
    endtask

    // mostly restart followed by a run of advances with random words; long runs
    // can exhaust the bitmap and wrap, short ones mostly cannot, with some noise mixed in
    task automatic test_random_rounds(input int unsigned n_items);
        int unsigned sent;
        int unsigned run_len;
        int unsigned roll;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 85) begin
                send_item(KIND_RESTART, $urandom());
                sent++;
            end
            run_len = ($urandom_range(99) < 60) ? $urandom_range(140, 100)
                                                : $urandom_range(40, 1);
            repeat (run_len) begin
                roll = $urandom_range(99);
                if (roll < 88)      send_item(KIND_ADVANCE, $urandom());
                else if (roll < 94) send_item(KIND_STATUS, $urandom());
                else if (roll < 97) send_item(KIND_SPARE, $urandom());
                else                send_item(KIND_RESTART, $urandom()); // broken round
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.kind         = KIND_STATUS;
        in_ch.random_value = '0;
        out_ch.ready       = 1'b0;
        done_map           = '0;
        cur_pick           = '0;
        mismatch_count     = 0;
        cycle_count        = 0;
        tx_idle_pct        = 16;
        rx_idle_pct        = 57;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed cases, sender idles lightly and receiver heavily
        test_reset_state();
        test_restart_extremes();
        test_advance_extremes();
        test_spare_kind();
        test_random_rounds(680);

        // swap the idling between the two sides
        tx_idle_pct = 57;
        rx_idle_pct = 16;
        test_random_rounds(660);

        // full rate on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_rounds(660);

        in_ch.valid <= 1'b0;

        // drain, then let an advance's worth of cycles pass for strays
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/rpwr_pkg.sv
hw/rtl/rpwr_if.sv
hw/rtl/rpwr_ctrl.sv
hw/rtl/rpwr_dp.sv
hw/rtl/random_pick_without_replacement.sv
dv/tb_random_pick_without_replacement.sv
